// ===== rtl/sdh_pkg.sv =====
// Shared types, constants and hash helpers for the seed derivation hash block.
// No dependencies; every other file of the block takes its names from here.
`default_nettype none

package sdh_pkg;

   // Number of characters absorbed after the prefix: '_', 8 hex, '_', 16 hex.
   localparam int unsigned NUM_CHARS = 26;

   // Configuration register indexes.
   localparam logic CSR_SINGLE_SEED = 1'b0;
   localparam logic CSR_PREFIX_HASH = 1'b1;

   localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0]  CHAR_DIGIT_ZERO = 8'h30;
   localparam logic [7:0]  CHAR_LETTER_A   = 8'h61;
   localparam logic [30:0] WORD_ZERO       = 31'h0;

   // Positions of the pending result bits in the emitter.
   localparam int unsigned PEND_SHORT = 0;
   localparam int unsigned PEND_LOW   = 1;
   localparam int unsigned PEND_HIGH  = 2;
   localparam int unsigned PEND_HASH  = 3;
   localparam int unsigned PEND_ZERO  = 4;
   localparam int unsigned PEND_BITS  = 5;

   typedef struct packed {
      logic [31:0] hash;
      logic [31:0] seed_short;
      logic [63:0] seed_long;
   } stage_type;

   // Character absorbed at a given step; the step is a constant at every use.
   function automatic logic [7:0] step_char(input logic [4:0] step,
                                            input logic [31:0] s1,
                                            input logic [63:0] s2);
      logic [3:0] nib;
      logic [7:0] res;
      nib = 4'h0;
      if (step inside {[5'd1:5'd8]}) begin
         nib = 4'(s1 >> {5'd8 - step, 2'b00});
      end else if (step inside {[5'd10:5'd25]}) begin
         nib = 4'(s2 >> {5'd25 - step, 2'b00});
      end
      if (step == 5'd0 || step == 5'd9) begin
         res = CHAR_UNDERSCORE;
      end else if (nib < 4'd10) begin
         res = CHAR_DIGIT_ZERO + {4'h0, nib};
      end else begin
         res = CHAR_LETTER_A + ({4'h0, nib} - 8'd10);
      end
      return res;
   endfunction

   // One character step of the one-at-a-time hash.
   function automatic logic [31:0] absorb(input logic [31:0] h_in, input logic [7:0] c);
      logic [31:0] h;
      h = h_in + {24'h0, c};
      h = h + (h << 10);
      h = h ^ 32'($signed(h) >>> 6);
      return h;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sdh_absorb_stage.sv =====
// One pipeline stage of the hash: absorbs one character into the running state.
// Depends on sdh_pkg for the stage payload type and the absorb step.
`default_nettype none

module sdh_absorb_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire sdh_pkg::stage_type in_data,
   input  wire logic [7:0]         in_char,
   output logic                    out_valid,
   output sdh_pkg::stage_type      out_data
);

   logic               valid_ff;
   sdh_pkg::stage_type data_ff;
   sdh_pkg::stage_type data_in;

   always_comb begin
      data_in      = in_data;
      data_in.hash = sdh_pkg::absorb(in_data.hash, in_char);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/sdh_finish.sv =====
// Final mixing of the hash over three stages, ending with the absolute value.
// Depends on sdh_pkg for the stage payload type.
`default_nettype none

module sdh_finish (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire sdh_pkg::stage_type in_data,
   output logic                    out_valid,
   output sdh_pkg::stage_type      out_data
);

   logic [2:0]         valid_ff;
   sdh_pkg::stage_type mix_a_ff, mix_b_ff, mag_ff;
   sdh_pkg::stage_type mix_a_in, mix_b_in, mag_in;
   logic [31:0]        t;

   always_comb begin
      t             = in_data.hash + (in_data.hash << 3);
      mix_a_in      = in_data;
      mix_a_in.hash = t ^ 32'($signed(t) >>> 11);
      mix_b_in      = mix_a_ff;
      mix_b_in.hash = mix_a_ff.hash + (mix_a_ff.hash << 15);
      // The magnitude of the most negative value wraps to 0x80000000 as wanted.
      mag_in        = mix_b_ff;
      mag_in.hash   = mix_b_ff.hash[31] ? (32'h0 - mix_b_ff.hash) : mix_b_ff.hash;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 3'b000;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mix_a_ff <= mix_a_in;
         mix_b_ff <= mix_b_in;
         mag_ff   <= mag_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = mag_ff;

endmodule

`default_nettype wire

// ===== rtl/sdh_emitter.sv =====
// Turns one finished request into its list of seeds, one result per cycle.
// Depends on sdh_pkg for the payload type and the pending-bit positions.
`default_nettype none

module sdh_emitter (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire sdh_pkg::stage_type in_data,
   input  wire logic               single_seed,
   output logic                    take,
   output logic                    rsp_strobe,
   output logic [31:0]             rsp_seed_value,
   output logic                    rsp_last_seed
);

   logic [sdh_pkg::PEND_BITS-1:0] pend_ff, pend_in;
   logic [30:0] word_short_ff, word_low_ff, word_high_ff;
   logic [31:0] mag_ff;
   logic        strobe_ff, strobe_in;
   logic        last_ff, last_in;
   logic [31:0] value_ff, value_in;
   logic [30:0] a_w, b_w, c_w;

   assign a_w = in_data.seed_short[30:0];
   assign b_w = in_data.seed_long[30:0];
   assign c_w = in_data.seed_long[62:32];

   // A new request is taken once only the closing zero (or nothing) is left.
   assign take = (pend_ff == '0) || (pend_ff == sdh_pkg::PEND_BITS'(1 << sdh_pkg::PEND_ZERO));

   always_comb begin
      strobe_in = |pend_ff;
      last_in   = 1'b0;
      value_in  = 32'h0;
      if (pend_ff[sdh_pkg::PEND_SHORT]) begin
         value_in = {1'b0, word_short_ff};
      end else if (pend_ff[sdh_pkg::PEND_LOW]) begin
         value_in = {1'b0, word_low_ff};
      end else if (pend_ff[sdh_pkg::PEND_HIGH]) begin
         value_in = {1'b0, word_high_ff};
      end else if (pend_ff[sdh_pkg::PEND_HASH]) begin
         value_in = mag_ff;
      end else if (pend_ff[sdh_pkg::PEND_ZERO]) begin
         last_in  = 1'b1;
      end

      pend_in = pend_ff & (pend_ff - 1'b1);
      if (take) begin
         pend_in = '0;
         if (in_valid) begin
            pend_in[sdh_pkg::PEND_ZERO]  = 1'b1;
            pend_in[sdh_pkg::PEND_HASH]  = 1'b1;
            pend_in[sdh_pkg::PEND_HIGH]  = !single_seed && (c_w != sdh_pkg::WORD_ZERO);
            pend_in[sdh_pkg::PEND_LOW]   = !single_seed && (b_w != sdh_pkg::WORD_ZERO);
            pend_in[sdh_pkg::PEND_SHORT] = !single_seed && (a_w != sdh_pkg::WORD_ZERO);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      value_ff <= value_in;
      if (take) begin
         word_short_ff <= a_w;
         word_low_ff   <= b_w;
         word_high_ff  <= c_w;
         mag_ff        <= in_data.hash;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_seed_value = value_ff;
   assign rsp_last_seed  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/seed_derivation_hash.sv =====
// Top level of the seed derivation hash: configuration registers, the absorb
// pipeline, the finish stages and the result emitter. Depends on sdh_pkg.
`default_nettype none

// Usage
// A request is presented on req_seed_short / req_seed_long together with start
// and is accepted at a rising edge where start is high and busy is low. Each
// request yields two to five results on rsp_seed_value / rsp_last_seed, each
// marked by rsp_strobe for exactly one cycle; the result with rsp_last_seed set
// closes the list and always carries the value zero.
// The hash runs through 26 absorb stages (one character each) and three finish
// stages; the emitter then loads the request into its pending bits and puts
// each result in its output registers on the result ports. Requests may be
// issued in back-to-back cycles; they fill the pipeline while the emitter
// drains earlier lists. The rate at which requests are accepted is set by
// the number of results in each list, since the result port carries one
// result per cycle. busy is high while the pipeline is held because its last
// stage waits on the emitter.
// The receiver cannot stall, so no result is ever held back or repeated.
// Configuration writes on the csr_ channel are always accepted (csr_ready is
// tied high) and must only be made while the block is idle: index 0 is the
// single-seed mode bit, index 1 the prefix hash state.
// Synchronous reset empties the pipeline and the emitter and clears both
// configuration registers.

module seed_derivation_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_seed_short,
   input  wire logic [63:0] req_seed_long,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_seed_value,
   output logic             rsp_last_seed,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int unsigned NC = sdh_pkg::NUM_CHARS;

   logic        single_seed_ff;
   logic [31:0] prefix_hash_ff;

   logic               advance;
   logic               emit_take;
   logic               fin_valid;
   sdh_pkg::stage_type fin_data;

   logic               abs_valid [0:NC];
   sdh_pkg::stage_type abs_data  [0:NC];
   logic [7:0]         abs_char  [0:NC-1];

   // Configuration registers; the write channel never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         single_seed_ff <= 1'b0;
         prefix_hash_ff <= 32'h0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sdh_pkg::CSR_SINGLE_SEED: begin
               single_seed_ff <= csr_data[0];
            end
            sdh_pkg::CSR_PREFIX_HASH: begin
               prefix_hash_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // The whole pipeline moves together; it holds only when the finished
   // request at its end cannot be handed to the emitter yet.
   assign advance = !fin_valid || emit_take;
   assign busy    = !advance;

   // Entry of the pipeline: a new request starts from the prefix state.
   assign abs_valid[0]           = start && !busy;
   assign abs_data[0].hash       = prefix_hash_ff;
   assign abs_data[0].seed_short = req_seed_short;
   assign abs_data[0].seed_long  = req_seed_long;

   for (genvar k = 0; k < NC; k++) begin : g_absorb
      assign abs_char[k] = sdh_pkg::step_char(5'(k), abs_data[k].seed_short,
                                              abs_data[k].seed_long);

      sdh_absorb_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (abs_valid[k]),
         .in_data   (abs_data[k]),
         .in_char   (abs_char[k]),
         .out_valid (abs_valid[k+1]),
         .out_data  (abs_data[k+1])
      );
   end

   sdh_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (abs_valid[NC]),
      .in_data   (abs_data[NC]),
      .out_valid (fin_valid),
      .out_data  (fin_data)
   );

   // The emitter expands each finished request into its ordered list.
   sdh_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (fin_valid),
      .in_data        (fin_data),
      .single_seed    (single_seed_ff),
      .take           (emit_take),
      .rsp_strobe     (rsp_strobe),
      .rsp_seed_value (rsp_seed_value),
      .rsp_last_seed  (rsp_last_seed)
   );

`ifndef SYNTHESIS
   // The closing result of a list always carries zero.
   a_last_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_seed |-> rsp_seed_value == 32'h0)
      else $error("closing result carries a nonzero value");

   // A list is never interrupted: a result that is not the last is followed
   // directly by another.
   a_list_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_seed |=> rsp_strobe)
      else $error("result list interrupted");

   // The pipeline only holds when a finished request is waiting at its end.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      busy |-> fin_valid)
      else $error("pipeline held with no finished request waiting");

   // An accepted request enters the first absorb stage at the next edge.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> abs_valid[1])
      else $error("accepted request lost at pipeline entry");
`endif

endmodule

`default_nettype wire
